// File: rtl/kspmc_pkg.sv
// Package for the key-stepped PWM motor controller.
// Holds register codes, configuration and result word types, and event codes.
// No dependencies.
package kspmc_pkg;

   localparam int CSR_ADDR_W = 5;

   // configuration register indexes (byte address = 4 * index)
   localparam logic [2:0] REG_PWM_PERIOD   = 3'd0;
   localparam logic [2:0] REG_DUTY_BASE    = 3'd1;
   localparam logic [2:0] REG_SHORT_POLLS  = 3'd2;
   localparam logic [2:0] REG_LONG_POLLS   = 3'd3;
   localparam logic [2:0] REG_IRQS_PER_POLL = 3'd4;
   localparam logic [2:0] REG_POLLS_PER_SEC = 3'd5;
   localparam logic [2:0] REG_AUTO_OFF_SEC  = 3'd6;

   // press event codes
   localparam logic [1:0] EVT_NONE  = 2'd0;
   localparam logic [1:0] EVT_SHORT = 2'd1;
   localparam logic [1:0] EVT_LONG  = 2'd2;

   typedef struct packed {
      logic [4:0]  pwm_period;
      logic [4:0]  duty_base;
      logic [7:0]  short_press_polls;
      logic [7:0]  long_press_polls;
      logic [7:0]  irqs_per_poll;
      logic [7:0]  polls_per_second;
      logic [15:0] auto_off_seconds;
   } cfg_type;

   typedef struct packed {
      logic       pwm_out;
      logic [5:0] lamp_bar;
      logic [2:0] level;
      logic [1:0] press_event;
      logic       sleep_request;
   } rsp_type;

endpackage

// File: rtl/kspmc_if.sv
// Valid/ready channel interfaces for the motor controller words.
// kspmc_req_if carries one main-loop pass, kspmc_rsp_if one result. No dependencies.
interface kspmc_req_if;
   logic valid;
   logic ready;
   logic key_down;
   logic timer_irq;

   modport source (output valid, output key_down, output timer_irq, input ready);
   modport sink   (input valid, input key_down, input timer_irq, output ready);
endinterface

interface kspmc_rsp_if;
   logic       valid;
   logic       ready;
   logic       pwm_out;
   logic [5:0] lamp_bar;
   logic [2:0] level;
   logic [1:0] press_event;
   logic       sleep_request;

   modport source (output valid, output pwm_out, output lamp_bar, output level,
                   output press_event, output sleep_request, input ready);
   modport sink   (input valid, input pwm_out, input lamp_bar, input level,
                   input press_event, input sleep_request, output ready);
endinterface

// File: rtl/kspmc_csr.sv
// APB-style configuration registers for the motor controller.
// Depends on kspmc_pkg.
module kspmc_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [kspmc_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [31:0]                      pwdata,
   output logic [31:0]                      prdata,
   output logic                             pready,
   output kspmc_pkg::cfg_type               cfg
);
   import kspmc_pkg::*;

   cfg_type    cfg_ff;
   cfg_type    cfg_in;
   logic       wr_en;
   logic [2:0] reg_idx;

   assign pready  = 1'b1;
   assign wr_en   = psel & penable & pwrite;
   assign reg_idx = paddr[4:2];
   assign cfg     = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_idx)
            REG_PWM_PERIOD:    cfg_in.pwm_period        = pwdata[4:0];
            REG_DUTY_BASE:     cfg_in.duty_base         = pwdata[4:0];
            REG_SHORT_POLLS:   cfg_in.short_press_polls = pwdata[7:0];
            REG_LONG_POLLS:    cfg_in.long_press_polls  = pwdata[7:0];
            REG_IRQS_PER_POLL: cfg_in.irqs_per_poll     = pwdata[7:0];
            REG_POLLS_PER_SEC: cfg_in.polls_per_second  = pwdata[7:0];
            REG_AUTO_OFF_SEC:  cfg_in.auto_off_seconds  = pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         REG_PWM_PERIOD:    prdata = {27'd0, cfg_ff.pwm_period};
         REG_DUTY_BASE:     prdata = {27'd0, cfg_ff.duty_base};
         REG_SHORT_POLLS:   prdata = {24'd0, cfg_ff.short_press_polls};
         REG_LONG_POLLS:    prdata = {24'd0, cfg_ff.long_press_polls};
         REG_IRQS_PER_POLL: prdata = {24'd0, cfg_ff.irqs_per_poll};
         REG_POLLS_PER_SEC: prdata = {24'd0, cfg_ff.polls_per_second};
         REG_AUTO_OFF_SEC:  prdata = {16'd0, cfg_ff.auto_off_seconds};
         default:           prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pwm_period        <= 5'd20;
         cfg_ff.duty_base         <= 5'd13;
         cfg_ff.short_press_polls <= 8'd8;
         cfg_ff.long_press_polls  <= 8'd200;
         cfg_ff.irqs_per_poll     <= 8'd100;
         cfg_ff.polls_per_second  <= 8'd100;
         cfg_ff.auto_off_seconds  <= 16'd900;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// File: rtl/kspmc_core.sv
// Per-pass controller state: prescalers, PWM slot, key classifier, level, sleep.
// Computes the result word for the offered pass; state advances on accept.
// Depends on kspmc_pkg.
module kspmc_core #(
   parameter int NUM_LEVELS = 7
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               accept,
   input  logic               key_down,
   input  logic               timer_irq,
   input  kspmc_pkg::cfg_type cfg,
   output kspmc_pkg::rsp_type rsp
);
   import kspmc_pkg::*;

   logic [4:0]  pwm_slot_ff,   pwm_slot_in;
   logic [4:0]  duty_ff,       duty_in;
   logic [2:0]  level_ff,      level_in;
   logic [5:0]  lamps_ff,      lamps_in;
   logic [7:0]  held_ff,       held_in;
   logic        fired_ff,      fired_in;
   logic [7:0]  irq_pre_ff,    irq_pre_in;
   logic [7:0]  poll_pre_ff,   poll_pre_in;
   logic [15:0] seconds_ff,    seconds_in;

   logic        poll;
   logic        pwm;
   logic [1:0]  event_code;
   logic        sleep;
   logic [7:0]  irq_inc;
   logic [7:0]  poll_inc;
   logic [4:0]  slot_inc;
   logic [7:0]  held_inc;
   logic [3:0]  level_inc;
   logic [5:0]  duty_sum;
   logic [8:0]  bar_mask;

   always_comb begin
      irq_pre_in  = irq_pre_ff;
      poll_pre_in = poll_pre_ff;
      seconds_in  = seconds_ff;
      poll        = 1'b0;
      irq_inc     = irq_pre_ff + 8'd1;
      poll_inc    = poll_pre_ff + 8'd1;

      if (timer_irq) begin
         irq_pre_in = irq_inc;
         if (irq_inc >= cfg.irqs_per_poll) begin
            irq_pre_in = 8'd0;
            poll       = 1'b1;
            if (level_ff != 3'd0) begin
               poll_pre_in = poll_inc;
               if (poll_inc >= cfg.polls_per_second) begin
                  poll_pre_in = 8'd0;
                  if (seconds_ff != 16'hFFFF) begin
                     seconds_in = seconds_ff + 16'd1;
                  end
               end
            end
         end
      end

      // PWM slot
      pwm      = (pwm_slot_ff < duty_ff);
      slot_inc = pwm_slot_ff + 5'd1;
      pwm_slot_in = (slot_inc >= cfg.pwm_period) ? 5'd0 : slot_inc;

      // key classifier
      held_in    = held_ff;
      fired_in   = fired_ff;
      event_code = EVT_NONE;
      held_inc   = (held_ff != 8'hFF) ? held_ff + 8'd1 : held_ff;
      if (poll) begin
         if (key_down) begin
            held_in = held_inc;
            if (held_inc >= cfg.long_press_polls) begin
               held_in = cfg.long_press_polls;
               if (!fired_ff) begin
                  fired_in   = 1'b1;
                  event_code = EVT_LONG;
               end
            end
         end else begin
            held_in = 8'd0;
            if (held_ff >= cfg.long_press_polls) begin
               fired_in = 1'b0;
            end else if (held_ff >= cfg.short_press_polls) begin
               event_code = EVT_SHORT;
            end
         end
      end

      // level, duty, lamps, sleep
      level_in  = level_ff;
      duty_in   = duty_ff;
      lamps_in  = lamps_ff;
      sleep     = 1'b0;
      level_inc = {1'b0, level_ff} + 4'd1;
      if (event_code == EVT_SHORT) begin
         level_in = (level_inc >= 4'(NUM_LEVELS)) ? 3'd0 : level_inc[2:0];
      end else if (event_code == EVT_LONG) begin
         level_in = 3'd0;
      end
      duty_sum = {1'b0, cfg.duty_base} + {3'd0, level_in};
      bar_mask = (9'd1 << level_in) - 9'd1;

      if (poll) begin
         if (level_in == 3'd0) begin
            duty_in  = 5'd0;
            lamps_in = 6'd0;
            pwm      = 1'b0;
            if (held_in == 8'd0) begin
               sleep = 1'b1;
            end
         end else begin
            duty_in  = duty_sum[5] ? 5'd31 : duty_sum[4:0];
            lamps_in = bar_mask[5:0];
         end
         if (seconds_in >= cfg.auto_off_seconds && held_in == 8'd0) begin
            sleep = 1'b1;
         end
         if (sleep) begin
            level_in   = 3'd0;
            seconds_in = 16'd0;
            duty_in    = 5'd0;
            lamps_in   = 6'd0;
            pwm        = 1'b0;
         end
      end

      rsp.pwm_out       = pwm;
      rsp.lamp_bar      = lamps_in;
      rsp.level         = level_in;
      rsp.press_event   = event_code;
      rsp.sleep_request = sleep;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pwm_slot_ff <= 5'd0;
         duty_ff     <= 5'd0;
         level_ff    <= 3'd0;
         lamps_ff    <= 6'd0;
         held_ff     <= 8'd0;
         fired_ff    <= 1'b0;
         irq_pre_ff  <= 8'd0;
         poll_pre_ff <= 8'd0;
         seconds_ff  <= 16'd0;
      end else if (accept) begin
         pwm_slot_ff <= pwm_slot_in;
         duty_ff     <= duty_in;
         level_ff    <= level_in;
         lamps_ff    <= lamps_in;
         held_ff     <= held_in;
         fired_ff    <= fired_in;
         irq_pre_ff  <= irq_pre_in;
         poll_pre_ff <= poll_pre_in;
         seconds_ff  <= seconds_in;
      end
   end

endmodule

// File: rtl/key_stepped_pwm_motor_controller.sv
// Key-stepped PWM motor controller: one main-loop pass per request word,
// one result word per pass. Depends on kspmc_pkg, kspmc_if, kspmc_csr, kspmc_core.
//
// Each request word is one main-loop pass (key level, timer interrupt flag).
// The controller takes one word per clock cycle while the request side is ready; its
// result appears in the output register on the next cycle. The request side is ready
// whenever the output register is empty or is being taken in the same cycle, so a
// stalled result holds back exactly one word. All per-pass state updates are computed
// combinationally between the controller state registers and the output register.
// Configuration registers sit at byte address 4*index and should be written
// only while no pass is in flight.
module key_stepped_pwm_motor_controller #(
   parameter int NUM_LEVELS = 7
) (
   input  logic                             clock,
   input  logic                             reset,
   kspmc_req_if.sink                        req_chan,
   kspmc_rsp_if.source                      rsp_chan,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [kspmc_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [31:0]                      pwdata,
   output logic [31:0]                      prdata,
   output logic                             pready
);
   import kspmc_pkg::*;

   cfg_type cfg;
   rsp_type core_rsp;
   rsp_type rsp_data_ff;
   logic    rsp_valid_ff;
   logic    accept;

   assign req_chan.ready = ~rsp_valid_ff | rsp_chan.ready;
   assign accept         = req_chan.valid & req_chan.ready;

   kspmc_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   kspmc_core #(
      .NUM_LEVELS (NUM_LEVELS)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .key_down  (req_chan.key_down),
      .timer_irq (req_chan.timer_irq),
      .cfg       (cfg),
      .rsp       (core_rsp)
   );

   // output word register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= core_rsp;
      end
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.pwm_out       = rsp_data_ff.pwm_out;
   assign rsp_chan.lamp_bar      = rsp_data_ff.lamp_bar;
   assign rsp_chan.level         = rsp_data_ff.level;
   assign rsp_chan.press_event   = rsp_data_ff.press_event;
   assign rsp_chan.sleep_request = rsp_data_ff.sleep_request;

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for key_stepped_pwm_motor_controller: drives main-loop passes,
// predicts every panel word in a behavioral model and compares it field by field.
// Depends on kspmc_pkg, kspmc_if and the controller RTL.
module testbench;
   import kspmc_pkg::*;

   localparam int NUM_LEVELS = 7;

   typedef struct packed {
      logic key;
      logic irq;
   } pass_type;

   typedef struct packed {
      logic [4:0]  slot;
      logic [4:0]  duty;
      logic [2:0]  level;
      logic [5:0]  lamps;
      logic [7:0]  held;
      logic        long_fired;
      logic [7:0]  irq_count;
      logic [7:0]  poll_count;
      logic [15:0] seconds;
   } motor_state_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        psel, penable, pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic        pready;

   kspmc_req_if req_if();
   kspmc_rsp_if rsp_if();

   key_stepped_pwm_motor_controller #(.NUM_LEVELS(NUM_LEVELS)) u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready)
   );

   // predictor state and register mirror
   motor_state_type motor;
   cfg_type         regs;

   pass_type pass_queue[$];
   rsp_type  expected_panel[$];
   int       passes_queued = 0;
   int       passes_taken = 0;
   int       fails = 0;
   int       filler_pct = 10;
   bit       stall_on = 1'b1;
   bit       req_took = 1'b0;
   int       send_gap = 0;
   int       sink_gap = 0;
   int       hold_ask = 0;
   int       hold_left = 0;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   initial begin
      #1_000_000;
      $display("FAIL");
      $finish;
   end

   // one main-loop pass of the controller
   function automatic rsp_type motor_pass(input logic key, input logic irq);
      rsp_type    word;
      logic       poll;
      logic       drive;
      logic [1:0] evt;
      logic       doze;
      int         sum;
      poll = 1'b0;
      evt  = EVT_NONE;
      doze = 1'b0;
      if (irq) begin
         motor.irq_count = motor.irq_count + 8'd1;
         if (motor.irq_count >= regs.irqs_per_poll) begin
            motor.irq_count = '0;
            poll = 1'b1;
            if (motor.level != 3'd0) begin
               motor.poll_count = motor.poll_count + 8'd1;
               if (motor.poll_count >= regs.polls_per_second) begin
                  motor.poll_count = '0;
                  if (motor.seconds != 16'hFFFF)
                     motor.seconds = motor.seconds + 16'd1;
               end
            end
         end
      end
      drive = (motor.slot < motor.duty);
      motor.slot = motor.slot + 5'd1;
      if (motor.slot >= regs.pwm_period)
         motor.slot = '0;
      if (poll) begin
         if (key) begin
            if (motor.held != 8'hFF)
               motor.held = motor.held + 8'd1;
            if (motor.held >= regs.long_press_polls) begin
               motor.held = regs.long_press_polls;
               if (!motor.long_fired) begin
                  motor.long_fired = 1'b1;
                  evt = EVT_LONG;
               end
            end
         end else if (motor.held >= regs.long_press_polls) begin
            // release after a long press: no event
            motor.held = '0;
            motor.long_fired = 1'b0;
         end else if (motor.held >= regs.short_press_polls) begin
            motor.held = '0;
            evt = EVT_SHORT;
         end else begin
            motor.held = '0;
         end
         if (evt == EVT_SHORT)
            motor.level = (int'(motor.level) + 1 >= NUM_LEVELS) ? 3'd0 : motor.level + 3'd1;
         else if (evt == EVT_LONG)
            motor.level = 3'd0;
         if (motor.level == 3'd0) begin
            motor.duty  = '0;
            motor.lamps = '0;
            drive = 1'b0;
            if (motor.held == 8'd0)
               doze = 1'b1;
         end else begin
            sum = int'(regs.duty_base) + int'(motor.level);
            motor.duty  = (sum > 31) ? 5'd31 : 5'(sum);
            motor.lamps = 6'((1 << motor.level) - 1);
         end
         if (motor.seconds >= regs.auto_off_seconds && motor.held == 8'd0)
            doze = 1'b1;
         if (doze) begin
            motor.level   = '0;
            motor.seconds = '0;
            motor.duty    = '0;
            motor.lamps   = '0;
            drive = 1'b0;
         end
      end
      word.pwm_out       = drive;
      word.lamp_bar      = motor.lamps;
      word.level         = motor.level;
      word.press_event   = evt;
      word.sleep_request = doze;
      return word;
   endfunction

   task automatic check_field(input string what, input int want_v, input int got_v);
      if (want_v != got_v) begin
         fails++;
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want_v, got_v);
      end
   endtask

   // request driver
   always @(negedge clock) begin : drive_passes
      pass_type nxt;
      if (reset) begin
         req_if.valid     <= 1'b0;
         req_if.key_down  <= 1'b0;
         req_if.timer_irq <= 1'b0;
      end else if (req_if.valid && !req_took) begin
         // word still on offer
      end else if (send_gap > 0) begin
         send_gap--;
         req_if.valid <= 1'b0;
      end else if (stall_on && $urandom_range(0, 5) == 0) begin
         send_gap = $urandom_range(0, 5);
         req_if.valid <= 1'b0;
      end else if (pass_queue.size() > 0) begin
         nxt = pass_queue.pop_front();
         req_if.valid     <= 1'b1;
         req_if.key_down  <= nxt.key;
         req_if.timer_irq <= nxt.irq;
      end else begin
         req_if.valid <= 1'b0;
      end
   end

   // result sink ready
   always @(negedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b1;
      end else if (hold_ask > 0) begin
         hold_left = hold_ask - 1;
         hold_ask = 0;
         rsp_if.ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_if.ready <= 1'b0;
      end else if (sink_gap > 0) begin
         sink_gap--;
         rsp_if.ready <= 1'b0;
      end else if (stall_on && $urandom_range(0, 5) == 0) begin
         sink_gap = $urandom_range(0, 5);
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= 1'b1;
      end
   end

   // monitor: predict on accepted passes, check accepted panel words
   always @(posedge clock) begin : check_panel
      rsp_type want;
      if (!reset) begin
         if (req_if.valid && req_if.ready) begin
            expected_panel.push_back(motor_pass(req_if.key_down, req_if.timer_irq));
            passes_taken++;
         end
         if (rsp_if.valid && rsp_if.ready) begin
            if (expected_panel.size() == 0) begin
               fails++;
               $display("%0t: unexpected word, expected none, got lvl %0d lamps %h",
                        $time, rsp_if.level, rsp_if.lamp_bar);
            end else begin
               want = expected_panel.pop_front();
               check_field("pwm_out", want.pwm_out, rsp_if.pwm_out);
               check_field("lamp_bar", want.lamp_bar, rsp_if.lamp_bar);
               check_field("level", want.level, rsp_if.level);
               check_field("press_event", want.press_event, rsp_if.press_event);
               check_field("sleep_request", want.sleep_request, rsp_if.sleep_request);
            end
         end
      end
      req_took <= !reset && req_if.valid && req_if.ready;
   end

   task automatic csr_write(input logic [2:0] idx, input logic [31:0] value);
      @(negedge clock);
      psel    = 1'b1;
      penable = 1'b0;
      pwrite  = 1'b1;
      paddr   = {idx, 2'b00};
      pwdata  = value;
      @(negedge clock);
      penable = 1'b1;
      @(posedge clock);
      while (!pready)
         @(posedge clock);
      case (idx)
         REG_PWM_PERIOD:    regs.pwm_period        = value[4:0];
         REG_DUTY_BASE:     regs.duty_base         = value[4:0];
         REG_SHORT_POLLS:   regs.short_press_polls = value[7:0];
         REG_LONG_POLLS:    regs.long_press_polls  = value[7:0];
         REG_IRQS_PER_POLL: regs.irqs_per_poll     = value[7:0];
         REG_POLLS_PER_SEC: regs.polls_per_second  = value[7:0];
         REG_AUTO_OFF_SEC:  regs.auto_off_seconds  = value[15:0];
         default: ;
      endcase
      @(negedge clock);
      psel    = 1'b0;
      penable = 1'b0;
      pwrite  = 1'b0;
   endtask

   task automatic set_config(input int period, input int base, input int short_n,
                             input int long_n, input int irqs, input int pps, input int off_s);
      csr_write(REG_PWM_PERIOD, period);
      csr_write(REG_DUTY_BASE, base);
      csr_write(REG_SHORT_POLLS, short_n);
      csr_write(REG_LONG_POLLS, long_n);
      csr_write(REG_IRQS_PER_POLL, irqs);
      csr_write(REG_POLLS_PER_SEC, pps);
      csr_write(REG_AUTO_OFF_SEC, off_s);
   endtask

   task automatic push_pass(input logic key, input logic irq);
      pass_queue.push_back(pass_type'{key: key, irq: irq});
      passes_queued++;
   endtask

   // n key polls at one key level; each poll takes irqs_per_poll interrupts
   task automatic push_polls(input logic key, input int n);
      int per_poll;
      per_poll = (regs.irqs_per_poll == 8'd0) ? 1 : int'(regs.irqs_per_poll);
      repeat (n) begin
         if ($urandom_range(0, 99) < filler_pct)
            push_pass(1'($urandom_range(0, 1)), 1'b0);
         repeat (per_poll)
            push_pass(key, 1'b1);
      end
   endtask

   task automatic push_press(input int held, input int idle);
      push_polls(1'b1, held);
      push_polls(1'b0, idle);
   endtask

   task automatic random_phase(input int n_items);
      int start;
      int kind;
      int lp;
      start = passes_queued;
      lp = (regs.long_press_polls == 8'd0) ? 1 : int'(regs.long_press_polls);
      while (passes_queued - start < n_items) begin
         kind = $urandom_range(0, 9);
         if (kind < 2) begin
            repeat ($urandom_range(1, 4))
               push_pass(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
         end else if (kind < 4) begin
            push_polls(1'b0, $urandom_range(1, 4));
         end else begin
            push_press($urandom_range(1, lp + 4), $urandom_range(1, 3));
         end
      end
   endtask

   task automatic wait_drained();
      while (passes_taken != passes_queued || expected_panel.size() != 0)
         @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   initial begin : stimulus
      reset            = 1'b1;
      psel             = 1'b0;
      penable          = 1'b0;
      pwrite           = 1'b0;
      paddr            = '0;
      pwdata           = '0;
      motor = '0;
      regs.pwm_period        = 5'd20;
      regs.duty_base         = 5'd13;
      regs.short_press_polls = 8'd8;
      regs.long_press_polls  = 8'd200;
      regs.irqs_per_poll     = 8'd100;
      regs.polls_per_second  = 8'd100;
      regs.auto_off_seconds  = 16'd900;
      repeat (8) @(negedge clock);
      reset = 1'b0;

      // reset register values: two polls at 100 interrupts each
      push_polls(1'b0, 2);
      wait_drained();

      // directed: step through all levels and wrap, long press and its release
      filler_pct = 0;
      set_config(31, 31, 1, 3, 1, 1, 65535);
      push_pass(1'b0, 1'b0);
      push_pass(1'b1, 1'b0);
      push_polls(1'b0, 1);
      repeat (7) push_press(1, 1);
      push_press(4, 1);
      wait_drained();
      // auto-off after two seconds at level 1
      set_config(5, 2, 1, 3, 1, 1, 2);
      push_press(1, 4);
      wait_drained();

      // zero period and prescalers, short threshold above long
      filler_pct = 10;
      set_config(0, 0, 255, 1, 0, 0, 1);
      random_phase(40);
      wait_drained();
      // held count saturates at 255 and fires the long press
      set_config(1, 31, 1, 255, 1, 255, 1);
      push_press(1, 1);
      push_press(258, 2);
      wait_drained();
      // slowest poll rate
      set_config(31, 0, 2, 5, 255, 1, 65535);
      push_polls(1'b0, 1);
      wait_drained();

      stall_on   = 1'b1;
      filler_pct = 10;
      for (int p = 0; p < 8; p++) begin
         set_config($urandom_range(0, 31), $urandom_range(0, 31), $urandom_range(0, 6),
                    $urandom_range(0, 14), $urandom_range(0, 3), $urandom_range(0, 4),
                    $urandom_range(1, 12));
         random_phase(95);
         // sink backs off while passes keep coming
         if (p == 0)
            hold_ask = 60;
         wait_drained();
      end

      stall_on = 1'b0;
      set_config($urandom_range(1, 31), $urandom_range(0, 31), $urandom_range(1, 6),
                 $urandom_range(2, 14), $urandom_range(1, 3), $urandom_range(1, 4),
                 $urandom_range(1, 12));
      random_phase(100);
      wait_drained();

      if (fails == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule

// File: sim.f
rtl/kspmc_pkg.sv
rtl/kspmc_if.sv
rtl/kspmc_csr.sv
rtl/kspmc_core.sv
rtl/key_stepped_pwm_motor_controller.sv
tb/testbench.sv
